FILE: rtl/core/spi_rule_motor_controller_defines.svh
// Assertion macros shared by the controller checker
`ifndef SPI_RULE_MOTOR_CONTROLLER_DEFINES_SVH
`define SPI_RULE_MOTOR_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define SRMC_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("srmc check failed");

// Next-cycle implication, disabled during reset
`define SRMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("srmc check failed");

`endif

FILE: rtl/core/srmc_pkg.sv
// Types and constants of the serial rule motor controller
`timescale 1ns / 1ps

package srmc_pkg;

   localparam int RuleDepthDefault = 16;

   localparam logic [6:0] OP_REGW  = 7'h01;
   localparam logic [6:0] OP_CLRH  = 7'h02;
   localparam logic [6:0] OP_RIFEQ = 7'h03;
   localparam logic [6:0] OP_RIFLT = 7'h04;
   localparam logic [6:0] OP_MODE  = 7'h05;

   localparam logic [6:0] REG_HOST     = 7'h00;
   localparam logic [6:0] REG_DUTY_ONE = 7'h01;
   localparam logic [6:0] REG_DUTY_TWO = 7'h02;
   localparam logic [6:0] REG_DIR_ONE  = 7'h03;
   localparam logic [6:0] REG_DIR_TWO  = 7'h04;
   localparam logic [6:0] REG_ADC      = 7'h05;
   localparam logic [6:0] REG_GPIO     = 7'h06;

   localparam logic [1:0] RX_OPCODE   = 2'd0;
   localparam logic [1:0] RX_REGISTER = 2'd1;
   localparam logic [1:0] RX_VALUE    = 2'd2;

   typedef struct packed {
      logic       less_than;
      logic [6:0] reg_addr;
      logic [6:0] value;
   } rule_type;

   // Poll token walking the cell row
   typedef struct packed {
      logic       valid;
      logic [7:0] adc;
      logic       gpio;
      logic       hit;
   } token_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } ctl_state_type;

endpackage

FILE: rtl/core/spi_rule_motor_controller.sv
// Serial rule motor controller top level
`timescale 1ns / 1ps

// Takes one item per transfer: a received serial byte (req_mode 0) or a poll
// tick (req_mode 1), and returns one result with the outputs after that item.
// A serial byte gives its result in the cycle after the transfer. A poll tick
// sends a token down the row of RULE_DEPTH rule cells, each cell registering
// it, and its result is registered once the token leaves the last cell. The
// next item is taken only once the result has been transferred. A new rule is
// registered into cell 0 as its value byte is taken, pushing older rules down.
module spi_rule_motor_controller #(
   parameter int RULE_DEPTH = srmc_pkg::RuleDepthDefault,
   localparam int CntW      = $clog2(RULE_DEPTH + 1)
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic       req_mode,
   input  logic [7:0] req_serial_byte,
   input  logic [9:0] req_adc_sample,
   input  logic       req_gpio_level,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_host_pin,
   output logic [6:0] rsp_motor_one_duty,
   output logic [6:0] rsp_motor_two_duty,
   output logic       rsp_motor_one_dir,
   output logic       rsp_motor_two_dir,
   output logic       rsp_gpio_is_output,
   output logic [4:0] rsp_rules_stored
);

   srmc_pkg::ctl_state_type state_ff, state_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              rx_count_ff, rx_count_in;
   logic [6:0]              pend_op_ff, pend_op_in;
   logic [6:0]              pend_reg_ff, pend_reg_in;
   logic                    host_ff, host_in;
   logic [6:0]              duty_one_ff, duty_one_in;
   logic [6:0]              duty_two_ff, duty_two_in;
   logic                    dir_one_ff, dir_one_in;
   logic                    dir_two_ff, dir_two_in;
   logic                    gpio_drv_ff, gpio_drv_in;
   logic [CntW-1:0]         rule_count_ff, rule_count_in;

   logic                    req_xfer;
   logic                    byte_xfer;
   logic                    walk_done;
   logic [6:0]              cmd_byte;
   logic                    push_rule;
   srmc_pkg::rule_type      push_data;
   logic [CntW+4:0]         count_ext;

   srmc_pkg::rule_type      rule_chain [0:RULE_DEPTH];
   srmc_pkg::token_type     tok_chain  [0:RULE_DEPTH];

   assign req_ready = (state_ff == srmc_pkg::ST_IDLE) && !rsp_valid_ff;
   assign req_xfer  = req_valid && req_ready;
   assign byte_xfer = req_xfer && !req_mode;
   assign cmd_byte  = req_serial_byte[7:1];
   assign walk_done = (state_ff == srmc_pkg::ST_WALK) && tok_chain[RULE_DEPTH].valid;

   assign tok_chain[0].valid = req_xfer && req_mode;
   assign tok_chain[0].adc   = req_adc_sample[9:2];
   assign tok_chain[0].gpio  = req_gpio_level;
   assign tok_chain[0].hit   = 1'b0;
   assign rule_chain[0]      = push_data;

   for (genvar i = 0; i < RULE_DEPTH; i++) begin : g_cell
      srmc_rule_cell #(
         .RULE_DEPTH (RULE_DEPTH),
         .INDEX      (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (push_rule),
         .rule_in    (rule_chain[i]),
         .rule_out   (rule_chain[i+1]),
         .rule_count (rule_count_ff),
         .tok_in     (tok_chain[i]),
         .tok_out    (tok_chain[i+1])
      );
   end

   always_comb begin
      state_in      = state_ff;
      rsp_valid_in  = rsp_valid_ff;
      rx_count_in   = rx_count_ff;
      pend_op_in    = pend_op_ff;
      pend_reg_in   = pend_reg_ff;
      host_in       = host_ff;
      duty_one_in   = duty_one_ff;
      duty_two_in   = duty_two_ff;
      dir_one_in    = dir_one_ff;
      dir_two_in    = dir_two_ff;
      gpio_drv_in   = gpio_drv_ff;
      rule_count_in = rule_count_ff;
      push_rule     = 1'b0;
      push_data.less_than = (pend_op_ff == srmc_pkg::OP_RIFLT);
      push_data.reg_addr  = pend_reg_ff;
      push_data.value     = cmd_byte;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         srmc_pkg::ST_IDLE: begin
            if (req_xfer && req_mode) begin
               state_in = srmc_pkg::ST_WALK;
            end
         end
         srmc_pkg::ST_WALK: begin
            if (walk_done) begin
               host_in      = host_ff | tok_chain[RULE_DEPTH].hit;
               rsp_valid_in = 1'b1;
               state_in     = srmc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = srmc_pkg::ST_IDLE;
         end
      endcase

      if (byte_xfer) begin
         rsp_valid_in = 1'b1;
         case (rx_count_ff)
            srmc_pkg::RX_OPCODE: begin
               if (cmd_byte == srmc_pkg::OP_CLRH) begin
                  host_in = 1'b0;
               end else if (cmd_byte inside {srmc_pkg::OP_REGW, srmc_pkg::OP_RIFEQ,
                                             srmc_pkg::OP_RIFLT, srmc_pkg::OP_MODE}) begin
                  pend_op_in  = cmd_byte;
                  rx_count_in = srmc_pkg::RX_REGISTER;
               end
            end
            srmc_pkg::RX_REGISTER: begin
               pend_reg_in = cmd_byte;
               rx_count_in = srmc_pkg::RX_VALUE;
            end
            default: begin
               // value byte completes the command
               if (pend_op_ff == srmc_pkg::OP_REGW) begin
                  case (pend_reg_ff)
                     srmc_pkg::REG_HOST:     host_in     = cmd_byte != 7'd0;
                     srmc_pkg::REG_DUTY_ONE: duty_one_in = cmd_byte;
                     srmc_pkg::REG_DUTY_TWO: duty_two_in = cmd_byte;
                     srmc_pkg::REG_DIR_ONE:  dir_one_in  = cmd_byte != 7'd0;
                     srmc_pkg::REG_DIR_TWO:  dir_two_in  = cmd_byte != 7'd0;
                     default: ;
                  endcase
               end else if (pend_op_ff inside {srmc_pkg::OP_RIFEQ, srmc_pkg::OP_RIFLT}) begin
                  if (rule_count_ff != CntW'(RULE_DEPTH)) begin
                     push_rule     = 1'b1;
                     rule_count_in = rule_count_ff + CntW'(1);
                  end
               end else if (pend_op_ff == srmc_pkg::OP_MODE) begin
                  if (pend_reg_ff == srmc_pkg::REG_GPIO && cmd_byte == 7'd0) begin
                     gpio_drv_in = 1'b0;
                  end else if (pend_reg_ff == srmc_pkg::REG_GPIO && cmd_byte == 7'd1) begin
                     gpio_drv_in = 1'b1;
                  end
               end
               rx_count_in = srmc_pkg::RX_OPCODE;
               pend_op_in  = 7'd0;
               pend_reg_in = 7'd0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= srmc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         rx_count_ff   <= srmc_pkg::RX_OPCODE;
         pend_op_ff    <= 7'd0;
         pend_reg_ff   <= 7'd0;
         host_ff       <= 1'b0;
         duty_one_ff   <= 7'd0;
         duty_two_ff   <= 7'd0;
         dir_one_ff    <= 1'b0;
         dir_two_ff    <= 1'b0;
         gpio_drv_ff   <= 1'b0;
         rule_count_ff <= '0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         rx_count_ff   <= rx_count_in;
         pend_op_ff    <= pend_op_in;
         pend_reg_ff   <= pend_reg_in;
         host_ff       <= host_in;
         duty_one_ff   <= duty_one_in;
         duty_two_ff   <= duty_two_in;
         dir_one_ff    <= dir_one_in;
         dir_two_ff    <= dir_two_in;
         gpio_drv_ff   <= gpio_drv_in;
         rule_count_ff <= rule_count_in;
      end
   end

   // State is frozen while a result waits, so results read it directly
   assign count_ext          = {5'b0, rule_count_ff};
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_host_pin       = host_ff;
   assign rsp_motor_one_duty = duty_one_ff;
   assign rsp_motor_two_duty = duty_two_ff;
   assign rsp_motor_one_dir  = dir_one_ff;
   assign rsp_motor_two_dir  = dir_two_ff;
   assign rsp_gpio_is_output = gpio_drv_ff;
   assign rsp_rules_stored   = count_ext[4:0];

endmodule

FILE: rtl/core/srmc_rule_cell.sv
// One rule cell: holds a stored rule and checks the passing poll token
`timescale 1ns / 1ps

module srmc_rule_cell #(
   parameter int RULE_DEPTH = srmc_pkg::RuleDepthDefault,
   parameter int INDEX      = 0,
   localparam int CntW      = $clog2(RULE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  shift_en,
   input  srmc_pkg::rule_type    rule_in,
   output srmc_pkg::rule_type    rule_out,
   input  logic [CntW-1:0]       rule_count,
   input  srmc_pkg::token_type   tok_in,
   output srmc_pkg::token_type   tok_out
);

   srmc_pkg::rule_type  rule_ff;
   srmc_pkg::token_type tok_ff;
   srmc_pkg::token_type tok_in_next;
   logic                active;
   logic                readable;
   logic [7:0]          read_val;
   logic                match;

   assign active = rule_count > CntW'(INDEX);

   always_comb begin
      readable = 1'b1;
      read_val = tok_in.adc;
      if (rule_ff.reg_addr == srmc_pkg::REG_ADC) begin
         read_val = tok_in.adc;
      end else if (rule_ff.reg_addr == srmc_pkg::REG_GPIO) begin
         read_val = {7'b0, tok_in.gpio};
      end else begin
         readable = 1'b0;
      end
      if (rule_ff.less_than) begin
         match = read_val < {1'b0, rule_ff.value};
      end else begin
         match = read_val == {1'b0, rule_ff.value};
      end
      tok_in_next     = tok_in;
      tok_in_next.hit = tok_in.hit | (active & readable & match);
   end

   // New rules enter at cell 0 and push older ones down the row
   always_ff @(posedge clock) begin
      if (shift_en) begin
         rule_ff <= rule_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff <= '0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign rule_out = rule_ff;
   assign tok_out  = tok_ff;

endmodule

FILE: rtl/core/srmc_checker.sv
// Port-level checks of the serial rule motor controller, bound to the top
`timescale 1ns / 1ps
`include "spi_rule_motor_controller_defines.svh"

module srmc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_mode,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_host_pin,
   input logic [4:0] rsp_rules_stored
);

   logic stall;
   logic byte_xfer;
   logic poll_xfer;

   assign stall     = rsp_valid && !rsp_ready;
   assign byte_xfer = req_valid && req_ready && !req_mode;
   assign poll_xfer = req_valid && req_ready && req_mode;

   `SRMC_ASSERT_NEXT(a_rsp_hold, clock, reset, stall, rsp_valid && $stable(rsp_host_pin))
   `SRMC_ASSERT_NOW(a_one_item, clock, reset, rsp_valid, !req_ready)
   `SRMC_ASSERT_NEXT(a_byte_lat, clock, reset, byte_xfer, rsp_valid)
   `SRMC_ASSERT_NEXT(a_poll_walk, clock, reset, poll_xfer, !rsp_valid && $stable(rsp_rules_stored))

endmodule

bind spi_rule_motor_controller srmc_checker u_srmc_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_mode         (req_mode),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_host_pin     (rsp_host_pin),
   .rsp_rules_stored (rsp_rules_stored)
);

FILE: dv/tb.sv
// Self-checking testbench for the serial rule motor controller
`timescale 1ns / 1ps

module tb;

   localparam int RULE_DEPTH = srmc_pkg::RuleDepthDefault;
   localparam int LONG_HOLD = 300;

   typedef struct packed {
      logic       host;
      logic [6:0] duty_one;
      logic [6:0] duty_two;
      logic       dir_one;
      logic       dir_two;
      logic       gpio_out;
      logic [4:0] rules;
   } motor_status_type;

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic       req_mode = 1'b0;
   logic [7:0] req_serial_byte = 8'd0;
   logic [9:0] req_adc_sample = 10'd0;
   logic       req_gpio_level = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic       rsp_host_pin;
   logic [6:0] rsp_motor_one_duty;
   logic [6:0] rsp_motor_two_duty;
   logic       rsp_motor_one_dir;
   logic       rsp_motor_two_dir;
   logic       rsp_gpio_is_output;
   logic [4:0] rsp_rules_stored;

   // controller state as the testbench tracks it
   logic [1:0] cmd_phase = srmc_pkg::RX_OPCODE;
   logic [6:0] cmd_opcode = 7'd0;
   logic [6:0] cmd_register = 7'd0;
   logic       host_lvl = 1'b0;
   logic [6:0] duty_one = 7'd0;
   logic [6:0] duty_two = 7'd0;
   logic       dir_one = 1'b0;
   logic       dir_two = 1'b0;
   logic       gpio_out = 1'b0;
   srmc_pkg::rule_type rules [RULE_DEPTH];
   int         rule_total = 0;

   motor_status_type pending_status_q[$];
   int mismatch_count = 0;
   int items_sent = 0;
   bit req_gaps_on = 1'b1;
   bit rsp_stalls_on = 1'b1;
   int hold_req_count = 0;
   int hold_ack_count = 0;
   int stall_left = 0;

   spi_rule_motor_controller #(
      .RULE_DEPTH(RULE_DEPTH)
   ) i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_mode           (req_mode),
      .req_serial_byte    (req_serial_byte),
      .req_adc_sample     (req_adc_sample),
      .req_gpio_level     (req_gpio_level),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_host_pin       (rsp_host_pin),
      .rsp_motor_one_duty (rsp_motor_one_duty),
      .rsp_motor_two_duty (rsp_motor_two_duty),
      .rsp_motor_one_dir  (rsp_motor_one_dir),
      .rsp_motor_two_dir  (rsp_motor_two_dir),
      .rsp_gpio_is_output (rsp_gpio_is_output),
      .rsp_rules_stored   (rsp_rules_stored)
   );

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // mostly back to back, some short gaps, a few long ones
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return 0;
      if (r < 94) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic motor_status_type advance_controller(input logic mode,
                                                          input logic [7:0] serial,
                                                          input logic [9:0] adc,
                                                          input logic gpio);
      logic [6:0] cmd;
      logic [7:0] seen;
      srmc_pkg::rule_type r;
      motor_status_type s;
      cmd = serial[7:1];
      if (!mode) begin
         case (cmd_phase)
            srmc_pkg::RX_OPCODE: begin
               if (cmd == srmc_pkg::OP_CLRH) begin
                  host_lvl = 1'b0;
               end else if (cmd == srmc_pkg::OP_REGW || cmd == srmc_pkg::OP_RIFEQ ||
                            cmd == srmc_pkg::OP_RIFLT || cmd == srmc_pkg::OP_MODE) begin
                  cmd_opcode = cmd;
                  cmd_phase = srmc_pkg::RX_REGISTER;
               end
            end
            srmc_pkg::RX_REGISTER: begin
               cmd_register = cmd;
               cmd_phase = srmc_pkg::RX_VALUE;
            end
            default: begin
               case (cmd_opcode)
                  srmc_pkg::OP_REGW: begin
                     case (cmd_register)
                        srmc_pkg::REG_HOST: host_lvl = (cmd != 7'd0);
                        srmc_pkg::REG_DUTY_ONE: duty_one = cmd;
                        srmc_pkg::REG_DUTY_TWO: duty_two = cmd;
                        srmc_pkg::REG_DIR_ONE: dir_one = (cmd != 7'd0);
                        srmc_pkg::REG_DIR_TWO: dir_two = (cmd != 7'd0);
                        default: ;
                     endcase
                  end
                  srmc_pkg::OP_RIFEQ, srmc_pkg::OP_RIFLT: begin
                     // a full table drops the rule
                     if (rule_total < RULE_DEPTH) begin
                        r.less_than = (cmd_opcode == srmc_pkg::OP_RIFLT);
                        r.reg_addr = cmd_register;
                        r.value = cmd;
                        rules[rule_total] = r;
                        rule_total++;
                     end
                  end
                  srmc_pkg::OP_MODE: begin
                     if (cmd_register == srmc_pkg::REG_GPIO && cmd <= 7'd1) gpio_out = cmd[0];
                  end
                  default: ;
               endcase
               cmd_phase = srmc_pkg::RX_OPCODE;
               cmd_opcode = 7'd0;
               cmd_register = 7'd0;
            end
         endcase
      end else begin
         // a tick only ever raises the host pin
         for (int i = 0; i < rule_total; i++) begin
            r = rules[i];
            if (r.reg_addr == srmc_pkg::REG_ADC || r.reg_addr == srmc_pkg::REG_GPIO) begin
               seen = (r.reg_addr == srmc_pkg::REG_ADC) ? adc[9:2] : {7'd0, gpio};
               if (r.less_than ? (seen < {1'b0, r.value}) : (seen == {1'b0, r.value}))
                  host_lvl = 1'b1;
            end
         end
      end
      s.host = host_lvl;
      s.duty_one = duty_one;
      s.duty_two = duty_two;
      s.dir_one = dir_one;
      s.dir_two = dir_two;
      s.gpio_out = gpio_out;
      s.rules = rule_total[4:0];
      return s;
   endfunction

   // called at a rising edge; returns at the edge where the transfer happens
   task automatic send_item(input logic mode, input logic [7:0] serial,
                            input logic [9:0] adc, input logic gpio);
      int gap;
      gap = req_gaps_on ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_serial_byte <= serial;
      req_adc_sample <= adc;
      req_gpio_level <= gpio;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_status_q.push_back(advance_controller(mode, serial, adc, gpio));
      items_sent++;
   endtask

   task automatic send_byte(input logic [6:0] cmd);
      logic [7:0] serial;
      serial = {cmd, 1'b0};
      serial[0] = 1'($urandom_range(0, 1));
      send_item(1'b0, serial, 10'($urandom), 1'($urandom));
   endtask

   task automatic send_command(input logic [6:0] op, input logic [6:0] reg_sel,
                               input logic [6:0] val);
      send_byte(op);
      send_byte(reg_sel);
      send_byte(val);
   endtask

   task automatic send_poll(input logic [9:0] adc, input logic gpio);
      send_item(1'b1, 8'($urandom), adc, gpio);
   endtask

   // fill in random bytes until the receiver waits for an opcode again
   task automatic sync_to_opcode();
      while (cmd_phase != srmc_pkg::RX_OPCODE) send_byte(7'($urandom));
   endtask

   task automatic send_random_rule();
      int pick;
      logic [6:0] op;
      logic [6:0] reg_sel;
      logic [6:0] val;
      pick = $urandom_range(0, 9);
      if (pick < 6) reg_sel = srmc_pkg::REG_ADC;
      else if (pick < 8) reg_sel = srmc_pkg::REG_GPIO;
      else reg_sel = 7'($urandom);
      op = $urandom_range(0, 1) ? srmc_pkg::OP_RIFLT : srmc_pkg::OP_RIFEQ;
      if (reg_sel == srmc_pkg::REG_GPIO && $urandom_range(0, 3) != 0)
         val = 7'($urandom_range(0, 2));
      else val = 7'($urandom);
      send_command(op, reg_sel, val);
   endtask

   task automatic send_random_command();
      int k;
      logic [6:0] reg_sel;
      logic [6:0] val;
      k = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) val = $urandom_range(0, 1) ? 7'h7F : 7'h00;
      else val = 7'($urandom);
      if (k < 60) begin
         if ($urandom_range(0, 9) < 8) reg_sel = 7'($urandom_range(0, 4));
         else reg_sel = 7'($urandom);
         send_command(srmc_pkg::OP_REGW, reg_sel, val);
      end else if (k < 80) begin
         if ($urandom_range(0, 4) < 4) reg_sel = srmc_pkg::REG_GPIO;
         else reg_sel = 7'($urandom);
         if ($urandom_range(0, 4) < 4) val = 7'($urandom_range(0, 2));
         send_command(srmc_pkg::OP_MODE, reg_sel, val);
      end else if (k < 88) begin
         send_random_rule();
      end else begin
         // opcode outside the command set
         if ($urandom_range(0, 1)) send_byte(7'd0);
         else send_byte(7'($urandom_range(6, 127)));
      end
   endtask

   // with rules stored, half the ticks aim at an ADC rule's threshold, one step either side
   task automatic send_random_poll();
      logic [9:0] adc;
      logic       gpio;
      logic [8:0] level;
      srmc_pkg::rule_type r;
      adc = 10'($urandom);
      gpio = 1'($urandom);
      if (rule_total > 0 && $urandom_range(0, 1)) begin
         r = rules[$urandom_range(0, rule_total - 1)];
         if (r.reg_addr == srmc_pkg::REG_ADC) begin
            level = 9'({2'b00, r.value} + $urandom_range(0, 2) - 1);
            adc[9:2] = level[7:0];
         end
      end
      send_poll(adc, gpio);
   endtask

   task automatic test_register_writes();
      send_command(srmc_pkg::OP_REGW, srmc_pkg::REG_HOST, 7'h7F);
      send_poll(10'h3FF, 1'b1);
      send_byte(srmc_pkg::OP_CLRH);
      send_command(srmc_pkg::OP_REGW, srmc_pkg::REG_DUTY_ONE, 7'h7F);
      send_command(srmc_pkg::OP_REGW, 7'h7F, 7'h00);
      send_command(srmc_pkg::OP_MODE, srmc_pkg::REG_GPIO, 7'd1);
   endtask

   task automatic test_unknown_opcodes();
      send_byte(7'd0);
      send_byte(7'h7F);
      send_byte(7'd6);
   endtask

   task automatic test_rule_match();
      send_command(srmc_pkg::OP_RIFEQ, srmc_pkg::REG_ADC, 7'd0);
      // tick lands between bytes of a command, which must survive it
      send_byte(srmc_pkg::OP_RIFLT);
      send_byte(srmc_pkg::REG_GPIO);
      send_poll(10'd3, 1'b1);
      send_byte(7'd1);
      send_byte(srmc_pkg::OP_CLRH);
      send_poll(10'h3FF, 1'b0);
   endtask

   task automatic test_mixed_traffic(input int n_items);
      int first;
      int pick;
      first = items_sent;
      while (items_sent - first < n_items) begin
         if ($urandom_range(0, 99) == 0) begin
            req_gaps_on = 1'($urandom_range(0, 1));
            rsp_stalls_on = 1'($urandom_range(0, 1));
         end
         pick = $urandom_range(0, 99);
         if (pick < 55) begin
            sync_to_opcode();
            send_random_command();
         end else if (pick < 80) begin
            send_random_poll();
         end else if (pick < 90) begin
            send_byte(srmc_pkg::OP_CLRH);
         end else begin
            send_byte(7'($urandom));
         end
      end
   endtask

   task automatic test_table_full();
      sync_to_opcode();
      while (rule_total < RULE_DEPTH) send_random_rule();
      repeat (3) send_random_rule();
      repeat (4) begin
         send_byte(srmc_pkg::OP_CLRH);
         send_random_poll();
      end
   endtask

   task automatic test_backpressure();
      req_gaps_on = 1'b0;
      hold_req_count++;
      repeat (40) begin
         if ($urandom_range(0, 2) == 0) send_random_poll();
         else send_byte(7'($urandom));
      end
      req_gaps_on = 1'b1;
   endtask

   task automatic check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t %s: expected %0d, actual %0d", $time, what, want, got);
         mismatch_count++;
      end
   endtask

   // receiver: random stalls, plus a long hold-off on request
   always @(posedge clock) begin
      if (hold_ack_count != hold_req_count) begin
         hold_ack_count = hold_req_count;
         stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left = stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if (rsp_stalls_on) stall_left = idle_len();
      end
   end

   always @(posedge clock) begin : check_results
      motor_status_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_status_q.size() == 0) begin
            $display("%0t result transfer: expected none, actual host %0d rules %0d",
                     $time, rsp_host_pin, rsp_rules_stored);
            mismatch_count++;
         end else begin
            want = pending_status_q.pop_front();
            check_field("host_level", want.host, rsp_host_pin);
            check_field("motor_one_duty", want.duty_one, rsp_motor_one_duty);
            check_field("motor_two_duty", want.duty_two, rsp_motor_two_duty);
            check_field("motor_one_dir", want.dir_one, rsp_motor_one_dir);
            check_field("motor_two_dir", want.dir_two, rsp_motor_two_dir);
            check_field("gpio_is_output", want.gpio_out, rsp_gpio_is_output);
            check_field("rules_stored", want.rules, rsp_rules_stored);
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_register_writes();
      test_unknown_opcodes();
      test_rule_match();
      test_mixed_traffic(550);
      test_table_full();
      test_backpressure();
      test_mixed_traffic(550);
      req_valid <= 1'b0;
      rsp_stalls_on = 1'b0;
      while (pending_status_q.size() != 0) @(posedge clock);
      repeat (RULE_DEPTH + 4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #15_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
